FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// whenever ante holds, cons must hold in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rbsh_pkg.sv
package rbsh_pkg;

    // coordinate format, signed Q16.16
    localparam int CoordW  = 32;
    localparam int FracW   = 16;
    // t = c - o
    localparam int TW      = CoordW + 1;
    // t*d product and its three-way sum
    localparam int MW      = TW + CoordW;
    localparam int SW      = MW + 2;
    // magnitude of a non-negative projection
    localparam int PW      = 2 * CoordW - 14;
    localparam int PSplit  = (PW + 1) / 2;
    localparam int PLW     = CoordW + PSplit + 1;
    localparam int FW      = CoordW + PW + 1;
    // closest point clamps
    localparam int QClampSh = 50;
    localparam int EClampSh = 30;
    localparam int EDW     = QClampSh + 3;
    localparam int EW      = EClampSh + 2;
    localparam int SqW     = 2 * (EW - 1);
    localparam int D2W     = SqW + 2;
    // radius path
    localparam int BaseW   = 17;
    localparam int ScaleW  = 16;
    localparam int KindW   = 3;
    localparam int RPW     = BaseW + ScaleW;
    localparam int RW      = RPW - 8;
    localparam int R2W     = 2 * RW;
    // square root pipeline
    localparam int SqSteps = R2W / 2;
    localparam int XW      = R2W + 1;
    localparam int DW      = PW + 2;
    // decoupling queue
    localparam int QDepth  = 4;
    localparam int QAW     = $clog2(QDepth);
    localparam int QCntW   = QAW + 1;
    // register file
    localparam int DataW   = 32;
    localparam int AddrW   = 5;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_SCALE    = 3'd3,
        REG_KIND     = 3'd4
    } reg_idx_t;

    typedef enum logic [KindW-1:0] {
        SHP_SPHERE   = 3'd0,
        SHP_CYLINDER = 3'd1,
        SHP_CUBE     = 3'd2,
        SHP_TETRA    = 3'd3,
        SHP_PLANE    = 3'd4
    } shape_t;

    typedef struct packed {
        logic signed [CoordW-1:0] center_x;
        logic signed [CoordW-1:0] center_y;
        logic signed [CoordW-1:0] center_z;
        logic [ScaleW-1:0]        uniform_scale;
        logic [KindW-1:0]         shape_kind;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                     miss;
        logic [PW-1:0]            p;
        logic signed [TW-1:0]     tx;
        logic signed [TW-1:0]     ty;
        logic signed [TW-1:0]     tz;
        logic signed [CoordW-1:0] dx;
        logic signed [CoordW-1:0] dy;
        logic signed [CoordW-1:0] dz;
    } qitem_t;

    // base radius per shape, Q16.16
    function automatic logic [BaseW-1:0] base_radius(input logic [KindW-1:0] kind);
        logic [BaseW-1:0] r;
        case (shape_t'(kind))
            SHP_SPHERE:   r = BaseW'(65536);
            SHP_CYLINDER: r = BaseW'(78643);
            SHP_CUBE:     r = BaseW'(113508);
            SHP_TETRA:    r = BaseW'(98304);
            SHP_PLANE:    r = BaseW'(92668);
            default:      r = BaseW'(98304);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/rbsh_ray_if.sv
interface rbsh_ray_if import rbsh_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

FILE: rtl/core/rbsh_hit_if.sv
interface rbsh_hit_if import rbsh_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [CoordW-1:0] hit_distance;

    modport source (output valid, hit, hit_distance, input ready);
    modport sink   (input valid, hit, hit_distance, output ready);
endinterface

FILE: rtl/core/rbsh_regs.sv
module rbsh_regs import rbsh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes; unmapped indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x      <= '0;
            cfg_reg.center_y      <= '0;
            cfg_reg.center_z      <= '0;
            cfg_reg.uniform_scale <= ScaleW'(256);
            cfg_reg.shape_kind    <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CENTER_X: cfg_reg.center_x      <= CoordW'(pwdata);
                REG_CENTER_Y: cfg_reg.center_y      <= CoordW'(pwdata);
                REG_CENTER_Z: cfg_reg.center_z      <= CoordW'(pwdata);
                REG_SCALE:    cfg_reg.uniform_scale <= pwdata[ScaleW-1:0];
                REG_KIND:     cfg_reg.shape_kind    <= pwdata[KindW-1:0];
                default:      ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_CENTER_X: prdata = DataW'(cfg_reg.center_x);
            REG_CENTER_Y: prdata = DataW'(cfg_reg.center_y);
            REG_CENTER_Z: prdata = DataW'(cfg_reg.center_z);
            REG_SCALE:    prdata = DataW'(cfg_reg.uniform_scale);
            REG_KIND:     prdata = DataW'(cfg_reg.shape_kind);
            default:      prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/rbsh_front.sv
module rbsh_front import rbsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rbsh_ray_if.sink   ray,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       q_push,
    output qitem_t     q_item
);

    logic fen;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [TW-1:0]     t1_reg [3];
    logic signed [CoordW-1:0] d1_reg [3];
    logic signed [MW-1:0]     m2_reg [3];
    logic signed [TW-1:0]     t2_reg [3];
    logic signed [CoordW-1:0] d2_reg [3];
    qitem_t                   it3_reg;

    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sum_sh;

    // whole front moves unless the last stage is blocked by a full queue
    assign fen       = !(v3_reg && q_full);
    assign ray.ready = fen;
    assign q_push    = v3_reg && !q_full;
    assign q_item    = it3_reg;

    assign sum    = SW'(m2_reg[0]) + SW'(m2_reg[1]) + SW'(m2_reg[2]);
    assign sum_sh = sum >>> FracW;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (fen)
        begin
            v1_reg <= ray.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            // stage 1: t = c - o
            t1_reg[0] <= TW'(cfg.center_x) - TW'(ray.origin_x);
            t1_reg[1] <= TW'(cfg.center_y) - TW'(ray.origin_y);
            t1_reg[2] <= TW'(cfg.center_z) - TW'(ray.origin_z);
            d1_reg[0] <= ray.dir_x;
            d1_reg[1] <= ray.dir_y;
            d1_reg[2] <= ray.dir_z;
            // stage 2: per-axis products
            for (int i = 0; i < 3; i++)
            begin
                m2_reg[i] <= MW'(t1_reg[i]) * MW'(d1_reg[i]);
                t2_reg[i] <= t1_reg[i];
                d2_reg[i] <= d1_reg[i];
            end
            // stage 3: projection and behind-origin test
            it3_reg.miss <= sum_sh[SW-1];
            it3_reg.p    <= sum_sh[PW-1:0];
            it3_reg.tx   <= t2_reg[0];
            it3_reg.ty   <= t2_reg[1];
            it3_reg.tz   <= t2_reg[2];
            it3_reg.dx   <= d2_reg[0];
            it3_reg.dy   <= d2_reg[1];
            it3_reg.dz   <= d2_reg[2];
        end
    end

endmodule

FILE: rtl/core/rbsh_queue.sv
`include "assert_macros.svh"

module rbsh_queue import rbsh_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qitem_t wr_item,
    input  logic   pop,
    output qitem_t head,
    output logic   full,
    output logic   empty
);

    qitem_t           mem_reg [QDepth];
    logic [QAW-1:0]   wp_reg, rp_reg;
    logic [QCntW-1:0] cnt_reg;

    assign full  = (cnt_reg == QCntW'(QDepth));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_item;
    end

    `ASSERT_ALWAYS(a_q_bound, clk, rst_n, cnt_reg <= QCntW'(QDepth), "queue overfilled")
    `ASSERT_IMPLIES(a_q_push_full, clk, rst_n, full, !push, "push into full queue")

endmodule

FILE: rtl/core/rbsh_back.sv
`include "assert_macros.svh"

module rbsh_back import rbsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  qitem_t     head,
    input  logic       q_empty,
    output logic       q_pop,
    rbsh_hit_if.source result
);

    logic ben;

    // B1: item off the queue
    logic   v1_reg;
    qitem_t it1_reg;
    // B2: split products d*p and radius product
    logic                     v2_reg, m2_reg;
    logic [PW-1:0]            p2_reg;
    logic signed [TW-1:0]     t2_reg [3];
    logic signed [PLW-1:0]    lo2_reg [3];
    logic signed [PLW-1:0]    hi2_reg [3];
    logic [RPW-1:0]           rp2_reg;
    // B3: clamped closest-point offsets
    logic                     v3_reg, m3_reg;
    logic [PW-1:0]            p3_reg;
    logic signed [EW-1:0]     e3_reg [3];
    logic [RW-1:0]            r3_reg;
    // B4: squares
    logic                     v4_reg, m4_reg;
    logic [PW-1:0]            p4_reg;
    logic [SqW-1:0]           sq4_reg [3];
    logic [R2W-1:0]           r24_reg;
    // square root pipeline, entry 0 is the radicand stage
    logic                     sv_reg [SqSteps+1];
    logic                     sm_reg [SqSteps+1];
    logic [PW-1:0]            sp_reg [SqSteps+1];
    logic [XW-1:0]            sx_reg [SqSteps+1];
    logic [XW-1:0]            sr_reg [SqSteps+1];
    // output register
    logic                     ov_reg, hit_reg;
    logic signed [CoordW-1:0] dist_reg;

    logic signed [FW-1:0]  full_prod [3];
    logic signed [FW-1:0]  q_sh [3];
    logic signed [FW-1:0]  q_cl [3];
    logic signed [EDW-1:0] e_w [3];
    logic signed [EDW-1:0] e_cl [3];
    logic [EW-2:0]         mag [3];
    logic [D2W-1:0]        d2;
    logic                  outside;
    logic signed [DW-1:0]  dist_w;
    logic signed [CoordW-1:0] dist_sat;
    logic [XW-1:0]         sbit  [SqSteps];
    logic [XW-1:0]         trial [SqSteps];
    logic                  take  [SqSteps];

    localparam logic signed [FW-1:0]  QHi = FW'(64'sd1 <<< QClampSh);
    localparam logic signed [FW-1:0]  QLo = -QHi;
    localparam logic signed [EDW-1:0] EHi = EDW'(64'sd1 <<< EClampSh);
    localparam logic signed [EDW-1:0] ELo = -EHi;
    localparam logic signed [DW-1:0]  DHi = DW'({1'b0, {(CoordW-1){1'b1}}});
    localparam logic signed [DW-1:0]  DLo = -DHi - DW'(1);

    // one stall for the whole back end, taken from the output register
    assign ben          = !ov_reg || result.ready;
    assign q_pop        = ben && !q_empty;
    assign result.valid = ov_reg;
    assign result.hit   = hit_reg;
    assign result.hit_distance = dist_reg;

    // closest point: rebuild d*p, floor shift, clamp, subtract t, clamp
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            full_prod[i] = FW'(lo2_reg[i]) + (FW'(hi2_reg[i]) <<< PSplit);
            q_sh[i]      = full_prod[i] >>> FracW;
            if (q_sh[i] > QHi)
                q_cl[i] = QHi;
            else if (q_sh[i] < QLo)
                q_cl[i] = QLo;
            else
                q_cl[i] = q_sh[i];
            e_w[i] = EDW'(q_cl[i]) - EDW'(t2_reg[i]);
            if (e_w[i] > EHi)
                e_cl[i] = EHi;
            else if (e_w[i] < ELo)
                e_cl[i] = ELo;
            else
                e_cl[i] = e_w[i];
            mag[i] = e3_reg[i][EW-1] ? (EW-1)'(-e3_reg[i]) : (EW-1)'(e3_reg[i]);
        end
    end

    assign d2      = D2W'(sq4_reg[0]) + D2W'(sq4_reg[1]) + D2W'(sq4_reg[2]);
    assign outside = d2 > D2W'(r24_reg);

    // square root step per stage: one result bit each
    always_comb
    begin
        for (int k = 0; k < SqSteps; k++)
        begin
            sbit[k]  = XW'(1) << (R2W - 2 - 2 * k);
            trial[k] = sr_reg[k] + sbit[k];
            take[k]  = sx_reg[k] >= trial[k];
        end
    end

    // entry distance and saturation
    assign dist_w = DW'(sp_reg[SqSteps]) - DW'(sr_reg[SqSteps]);
    always_comb
    begin
        if (dist_w > DHi)
            dist_sat = DHi[CoordW-1:0];
        else if (dist_w < DLo)
            dist_sat = DLo[CoordW-1:0];
        else
            dist_sat = dist_w[CoordW-1:0];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            for (int k = 0; k <= SqSteps; k++)
                sv_reg[k] <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else if (ben)
        begin
            v1_reg    <= !q_empty;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            sv_reg[0] <= v4_reg;
            for (int k = 0; k < SqSteps; k++)
                sv_reg[k+1] <= sv_reg[k];
            ov_reg    <= sv_reg[SqSteps];
        end
    end

    // datapath stages B1..B4, square root and output
    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            it1_reg <= head;

            m2_reg     <= it1_reg.miss;
            p2_reg     <= it1_reg.p;
            t2_reg[0]  <= it1_reg.tx;
            t2_reg[1]  <= it1_reg.ty;
            t2_reg[2]  <= it1_reg.tz;
            lo2_reg[0] <= PLW'(it1_reg.dx) * PLW'($signed({1'b0, it1_reg.p[PSplit-1:0]}));
            lo2_reg[1] <= PLW'(it1_reg.dy) * PLW'($signed({1'b0, it1_reg.p[PSplit-1:0]}));
            lo2_reg[2] <= PLW'(it1_reg.dz) * PLW'($signed({1'b0, it1_reg.p[PSplit-1:0]}));
            hi2_reg[0] <= PLW'(it1_reg.dx) * PLW'($signed({1'b0, it1_reg.p[PW-1:PSplit]}));
            hi2_reg[1] <= PLW'(it1_reg.dy) * PLW'($signed({1'b0, it1_reg.p[PW-1:PSplit]}));
            hi2_reg[2] <= PLW'(it1_reg.dz) * PLW'($signed({1'b0, it1_reg.p[PW-1:PSplit]}));
            rp2_reg    <= RPW'(base_radius(cfg.shape_kind)) * RPW'(cfg.uniform_scale);

            m3_reg <= m2_reg;
            p3_reg <= p2_reg;
            r3_reg <= rp2_reg[RPW-1:8];
            for (int i = 0; i < 3; i++)
                e3_reg[i] <= EW'(e_cl[i]);

            m4_reg  <= m3_reg;
            p4_reg  <= p3_reg;
            r24_reg <= R2W'(r3_reg) * R2W'(r3_reg);
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= SqW'(mag[i]) * SqW'(mag[i]);

            // radicand; only meaningful when inside the sphere
            sm_reg[0] <= m4_reg || outside;
            sp_reg[0] <= p4_reg;
            sx_reg[0] <= XW'(r24_reg - d2[R2W-1:0]);
            sr_reg[0] <= '0;

            for (int k = 0; k < SqSteps; k++)
            begin
                sm_reg[k+1] <= sm_reg[k];
                sp_reg[k+1] <= sp_reg[k];
                sx_reg[k+1] <= take[k] ? sx_reg[k] - trial[k] : sx_reg[k];
                sr_reg[k+1] <= take[k] ? (sr_reg[k] >> 1) + sbit[k] : sr_reg[k] >> 1;
            end

            hit_reg  <= !sm_reg[SqSteps];
            dist_reg <= sm_reg[SqSteps] ? '0 : dist_sat;
        end
    end

    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, ov_reg && !hit_reg, dist_reg == '0, "miss with distance")
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, !q_empty, "pop from empty queue")

endmodule

FILE: rtl/core/ray_bounding_sphere_hit.sv
// Ray versus bounding sphere test. One ray (origin, unit direction, Q16.16) is
// taken per clock while the result side keeps taking items, and each gives
// one result: hit and the entry distance (Q16.16, saturated, 0 on a miss).
// Center, Q8.8 scale and shape kind are APB registers, to be written only
// while the block is idle; the user must ensure this, the block does not.
// A 3-stage front computes the projection and flags rays pointing away; a
// 4-entry queue decouples it from the back end, which rebuilds the closest
// point, its squared distance and a 25-stage square root, one result bit per
// stage. The latency from acceptance to the result going valid is set mostly
// by the square root pipeline.
module ray_bounding_sphere_hit import rbsh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rbsh_ray_if.sink         ray,
    rbsh_hit_if.source       result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    cfg_t   cfg;
    qitem_t q_in, q_head;
    logic   q_push, q_pop, q_full, q_empty;

    rbsh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rbsh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ray     (ray),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in)
    );

    rbsh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_in),
        .pop     (q_pop),
        .head    (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    rbsh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule
